// ===== hdl/set_assoc_lru_cache_tag_store_macros.svh =====
// Assertion macros for the cache tag store
`ifndef SET_ASSOC_LRU_CACHE_TAG_STORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAG_STORE_MACROS_SVH

// checked only outside reset
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SALC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/salc_pkg.sv =====
// Shared types for the cache tag store
package salc_pkg;

  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic scan;
    logic upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/salc_ram.sv =====
// Generic single-write, single-read RAM with registered read
module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/salc_ctrl.sv =====
// Sequencer: divide, scan the set, update the set, hand off the word
module salc_ctrl #(
  parameter int unsigned CW = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  salc_pkg::status_t status,
  input  logic [CW-1:0]     ways,
  output salc_pkg::cmd_t    cmd,
  output logic [CW-1:0]     cnt
);
  import salc_pkg::*;

  state_t        state, state_next;
  logic [CW-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt + CW'(1);
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (cnt == CW'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (cnt == ways) begin
          cnt_next   = '0;
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        // a hit rewrites one entry; a miss walks the whole set
        if (status.hit || cnt == ways) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cnt_next = '0;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        cnt_next   = '0;
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_stall = (state != ST_IDLE);
endmodule

// ===== hdl/salc_dp.sv =====
// Datapath: set/tag divider, tag and age RAM, valid bits, scan and totals
module salc_dp #(
  parameter int unsigned ENTRIES  = 32,
  parameter int unsigned AGE_BITS = 6,
  parameter int unsigned CW       = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  salc_pkg::cmd_t    cmd,
  input  logic [CW-1:0]     cnt,
  output salc_pkg::status_t status,
  output logic [CW-1:0]     ways,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_data,
  input  logic [31:0]       address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              hit,
  output logic [4:0]        way,
  output logic [31:0]       hit_total,
  output logic [31:0]       miss_total
);
  import salc_pkg::*;

  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned SW = $clog2(ENTRIES + 1);
  localparam int unsigned RW = 32 + AGE_BITS;

  logic [2:0]          wl;
  logic [ENTRIES-1:0]  valid;
  logic [31:0]         addr_sh, quo;
  logic [SW-1:0]       rem;
  logic [SW:0]         rem_s;
  logic                clamped;
  logic [SW-1:0]       sets;
  logic [31:0]         base;
  logic                hit_q, inv_found;
  logic [EW-1:0]       hit_way, inv_way, max_way, used, idx;
  logic [AGE_BITS-1:0] max_age, rage;
  logic [31:0]         rtag;
  logic [EW-1:0]       rd_entry, wr_entry;
  logic                rd_on;
  logic                we;
  logic [RW-1:0]       wdata, rdata;

  assign clamped = (32'(1) << wl) > 32'(ENTRIES);
  assign ways    = clamped ? CW'(ENTRIES) : CW'(32'(1) << wl);
  assign sets    = clamped ? SW'(1) : SW'(32'(ENTRIES) >> wl);
  assign base    = clamped ? 32'd0 : (32'(rem) << wl);
  assign rem_s   = {rem, addr_sh[31]};

  assign idx      = EW'(cnt - CW'(1));
  assign rd_on    = (cmd.scan || cmd.upd) && (cnt < ways);
  assign rd_entry = EW'(base + 32'(cnt));
  assign wr_entry = cmd.upd && hit_q ? EW'(base + 32'(hit_way)) : EW'(base + 32'(idx));
  assign rtag     = rdata[RW-1:AGE_BITS];
  assign rage     = rdata[AGE_BITS-1:0];
  assign used     = inv_found ? inv_way : max_way;

  always_comb begin
    we    = 1'b0;
    wdata = {quo, AGE_BITS'(0)};
    if (cmd.upd) begin
      if (hit_q) begin
        we = (cnt == '0);
      end else if (cnt != '0) begin
        we = 1'b1;
        if (idx != used) begin
          wdata = {rtag, (rage == '1) ? rage : rage + AGE_BITS'(1)};
        end
      end
    end
  end

  salc_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_entry),
    .wdata (wdata),
    .raddr (rd_on ? rd_entry : '0),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wl         <= 3'd2;
      valid      <= '0;
      out_valid  <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
    end else begin
      if (cfg_we) begin
        wl    <= cfg_data;
        valid <= '0;
      end else if (we && !hit_q && idx == used) begin
        // only the refilled way turns valid; the rest of the set just ages
        valid[wr_entry] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if (hit_q) begin
          if (hit_total != '1) hit_total <= hit_total + 32'd1;
        end else if (miss_total != '1) begin
          miss_total <= miss_total + 32'd1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_sh   <= address;
      rem       <= '0;
      quo       <= '0;
      hit_q     <= 1'b0;
      inv_found <= 1'b0;
      hit_way   <= '0;
      inv_way   <= '0;
      max_way   <= '0;
      max_age   <= '0;
    end
    if (cmd.div) begin
      // restoring division, one quotient bit per cycle
      addr_sh <= addr_sh << 1;
      if (rem_s >= {1'b0, sets}) begin
        rem <= SW'(rem_s - {1'b0, sets});
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= SW'(rem_s);
        quo <= {quo[30:0], 1'b0};
      end
    end
    if (cmd.scan && cnt != '0) begin
      if (!hit_q && valid[EW'(base + 32'(idx))] && rtag == quo) begin
        hit_q   <= 1'b1;
        hit_way <= idx;
      end
      if (!inv_found && !valid[EW'(base + 32'(idx))]) begin
        inv_found <= 1'b1;
        inv_way   <= idx;
      end
      if (rage > max_age) begin
        max_age <= rage;
        max_way <= idx;
      end
    end
    if (cmd.out_load) begin
      hit <= hit_q;
      way <= 5'(32'(hit_q ? hit_way : used));
    end
  end

  assign status.hit      = hit_q;
  assign status.out_free = !out_valid || !out_stall;
endmodule

// ===== hdl/set_assoc_lru_cache_tag_store.sv =====
// Top level of the set-associative LRU cache tag store
//
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    address
// output    out        out_valid / out_stall  hit, way, hit_total, miss_total
// config    in         ways_log2_we           ways_log2
//
// A word is loaded, split into set and tag by the bit-serial divider, scanned over
// its set, updated (one entry on a hit, every way of the set on a miss) and handed
// off; the divider and the single RAM port that walks the set bound the word rate.
// Reset clears valid bits, totals and control; writing ways_log2 clears valid bits.
// A finished word waits in the output register; the next word is taken meanwhile.
module set_assoc_lru_cache_tag_store #(
  parameter int unsigned ENTRIES  = 32,
  parameter int unsigned AGE_BITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ways_log2_we,
  input  logic [2:0]  ways_log2,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [4:0]  way,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total
);
  import salc_pkg::*;
  `include "set_assoc_lru_cache_tag_store_macros.svh"

  localparam int unsigned CW = ($clog2(ENTRIES + 1) > 6) ? $clog2(ENTRIES + 1) : 6;

  cmd_t          cmd;
  status_t       status;
  logic [CW-1:0] cnt, ways;

  salc_ctrl #(.CW(CW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ways     (ways),
    .cmd      (cmd),
    .cnt      (cnt)
  );

  salc_dp #(.ENTRIES(ENTRIES), .AGE_BITS(AGE_BITS), .CW(CW)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cnt        (cnt),
    .status     (status),
    .ways       (ways),
    .cfg_we     (ways_log2_we),
    .cfg_data   (ways_log2),
    .address    (address),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .way        (way),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

  `SALC_ASSERT(busy_after_accept, in_valid && !in_stall |=> in_stall, "accepted word not in progress")
  `SALC_ASSERT(out_hold, out_valid && out_stall |=> out_valid && $stable(way), "stalled word lost")
  `SALC_ASSERT_ALWAYS(reset_clears_out, $past(rst) |-> !out_valid, "out_valid after reset")
endmodule
